@@ src/kway_merge_min_queue_macros.svh @@
// Assertion macros for the merge queue top level
`ifndef KWAY_MERGE_MIN_QUEUE_MACROS_SVH
`define KWAY_MERGE_MIN_QUEUE_MACROS_SVH

`ifndef SYNTH
// Same-cycle implication check
`define KWM_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("kwm: same-cycle check failed");
// Next-cycle implication check
`define KWM_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("kwm: next-cycle check failed");
`else
`define KWM_ASSERT_IMP(label, clk, rst, ante, cons)
`define KWM_ASSERT_NXT(label, clk, rst, ante, cons)
`endif

`endif

@@ src/kwm_pkg.sv @@
// Types and constants of the k-way merge min queue
`default_nettype none

package kwm_pkg;

   localparam int SRC_W      = 3;
   localparam int VAL_W      = 31;
   localparam int CFG_W      = 4;
   localparam int WAYS_DEF   = 8;
   localparam int SRC_REACH  = 1 << SRC_W;
   localparam logic [CFG_W-1:0] ACTIVE_RESET = CFG_W'(8);

   typedef enum logic [1:0] {
      PH_PRIMING,
      PH_MERGING,
      PH_DONE
   } phase_type;

   // One held head value of a run
   typedef struct packed {
      logic             valid;
      logic [SRC_W-1:0] source;
      logic [VAL_W-1:0] value;
   } entry_type;

   // Per-cycle command to every cell of the chain
   typedef struct packed {
      logic flush;
      logic insert;
      logic pop;
   } chain_ctrl_type;

endpackage

`default_nettype wire

@@ src/kwm_cell.sv @@
// One cell of the sorted chain: holds one entry, inserts and shifts with neighbours
`default_nettype none

module kwm_cell (
   input  wire                     clock,
   input  wire                     reset,
   input  kwm_pkg::chain_ctrl_type ctrl,
   input  kwm_pkg::entry_type      key,
   input  kwm_pkg::entry_type      lower_entry,
   input  wire                     lower_keep,
   input  kwm_pkg::entry_type      upper_entry,
   input  wire                     upper_keep,
   output kwm_pkg::entry_type      cur_entry,
   output logic                    keep,
   output kwm_pkg::entry_type      post_entry
);
   import kwm_pkg::*;

   logic                 valid_ff;
   logic                 valid_in;
   logic [SRC_W-1:0]     source_ff;
   logic [SRC_W-1:0]     source_in;
   logic [VAL_W-1:0]     value_ff;
   logic [VAL_W-1:0]     value_in;
   logic                 greater;
   entry_type            post_upper;
   entry_type            entry_in;

   // Drop contents on a flush
   always_comb begin
      cur_entry.valid  = valid_ff & ~ctrl.flush;
      cur_entry.source = source_ff;
      cur_entry.value  = value_ff;
   end

   // Order by value, then by source
   always_comb begin
      greater = (value_ff > key.value) ||
                ((value_ff == key.value) && (source_ff > key.source));
      keep    = cur_entry.valid & ~greater;
   end

   // Contents of this place and the one above after the insert
   always_comb begin
      if (!ctrl.insert || keep) begin
         post_entry = cur_entry;
      end else if (lower_keep) begin
         post_entry = key;
      end else begin
         post_entry = lower_entry;
      end

      if (!ctrl.insert || upper_keep) begin
         post_upper = upper_entry;
      end else if (keep) begin
         post_upper = key;
      end else begin
         post_upper = cur_entry;
      end
   end

   // Advance towards the head on a pop
   always_comb begin
      entry_in  = ctrl.pop ? post_upper : post_entry;
      valid_in  = entry_in.valid;
      source_in = entry_in.source;
      value_in  = entry_in.value;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      source_ff <= source_in;
      value_ff  <= value_in;
   end

endmodule

`default_nettype wire

@@ src/kwm_chain.sv @@
// Row of sorted cells holding one head value per run, smallest at place zero
`default_nettype none

module kwm_chain #(
   parameter int WAYS = kwm_pkg::WAYS_DEF
) (
   input  wire                     clock,
   input  wire                     reset,
   input  kwm_pkg::chain_ctrl_type ctrl,
   input  kwm_pkg::entry_type      key,
   output kwm_pkg::entry_type      head,
   output logic                    full
);
   import kwm_pkg::*;

   entry_type cur_q  [WAYS];
   entry_type post_q [WAYS];
   logic      keep_q [WAYS];

   localparam entry_type EMPTY = '0;

   // Chain the cells, empty ends on both sides
   for (genvar i = 0; i < WAYS; i++) begin : g_stage
      entry_type lower_entry;
      logic      lower_keep;
      entry_type upper_entry;
      logic      upper_keep;

      if (i == 0) begin : g_first
         assign lower_entry = EMPTY;
         assign lower_keep  = 1'b1;
      end else begin : g_inner_lo
         assign lower_entry = cur_q[i-1];
         assign lower_keep  = keep_q[i-1];
      end

      if (i == WAYS - 1) begin : g_last
         assign upper_entry = EMPTY;
         assign upper_keep  = 1'b0;
      end else begin : g_inner_hi
         assign upper_entry = cur_q[i+1];
         assign upper_keep  = keep_q[i+1];
      end

      kwm_cell u_stage (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (ctrl),
         .key         (key),
         .lower_entry (lower_entry),
         .lower_keep  (lower_keep),
         .upper_entry (upper_entry),
         .upper_keep  (upper_keep),
         .cur_entry   (cur_q[i]),
         .keep        (keep_q[i]),
         .post_entry  (post_q[i])
      );
   end

   // Head after this cycle's insert; full when the top place holds a value
   assign head = post_q[0];
   assign full = cur_q[WAYS-1].valid;

endmodule

`default_nettype wire

@@ src/kway_merge_min_queue.sv @@
// Top level of the k-way merge min queue
// Merges up to eight ascending runs into one ascending stream. After a csr write of
// active_ways (0 counts as 1, capped at the cell count and at eight), send one head
// item per run in source order; the last of these produces the first result. Each
// later item must be the refill (value or exhausted) from the source of the result
// just given; a mismatching source returns an error result and is otherwise ignored.
// A done result closes the pass, and the next item starts a fresh one. Each item is
// taken at once: the row of WAYS sorted cells inserts the refill and shifts the
// head out in the same clock, so items may follow back to back; a result appears in
// the output register in the cycle after its item and the input keeps flowing while
// that register is free or being drained. Ties leave the lower source first.
`default_nettype none

`include "kway_merge_min_queue_macros.svh"

module kway_merge_min_queue #(
   parameter int WAYS = kwm_pkg::WAYS_DEF
) (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        req_valid,
   output logic                       req_stall,
   input  wire  [kwm_pkg::SRC_W-1:0]  req_source,
   input  wire  [kwm_pkg::VAL_W-1:0]  req_value,
   input  wire                        req_exhausted,
   output logic                       rsp_valid,
   input  wire                        rsp_stall,
   output logic [kwm_pkg::SRC_W-1:0]  rsp_out_source,
   output logic [kwm_pkg::VAL_W-1:0]  rsp_out_value,
   output logic                       rsp_done_res,
   output logic                       rsp_source_error,
   input  wire                        csr_valid,
   output logic                       csr_ready,
   input  wire  [kwm_pkg::CFG_W-1:0]  csr_active_ways
);
   import kwm_pkg::*;

   localparam int CAP = (WAYS < SRC_REACH) ? WAYS : SRC_REACH;
   localparam logic [CFG_W-1:0] CAP_W = CFG_W'(CAP);

   phase_type        phase_ff;
   phase_type        phase_in;
   logic [CFG_W-1:0] primed_ff;
   logic [CFG_W-1:0] primed_in;
   logic [SRC_W-1:0] awaited_ff;
   logic [SRC_W-1:0] awaited_in;
   logic [CFG_W-1:0] active_ff;
   logic [CFG_W-1:0] active_in;

   logic             rsp_valid_ff;
   logic             rsp_valid_in;
   logic [SRC_W-1:0] rsp_out_source_ff;
   logic [SRC_W-1:0] rsp_out_source_in;
   logic [VAL_W-1:0] rsp_out_value_ff;
   logic [VAL_W-1:0] rsp_out_value_in;
   logic             rsp_done_res_ff;
   logic             rsp_done_res_in;
   logic             rsp_source_error_ff;
   logic             rsp_source_error_in;

   logic             csr_write;
   logic             take;
   logic             restart;
   phase_type        phase_cur;
   logic [CFG_W-1:0] cnt_cur;
   logic [CFG_W-1:0] cnt_inc;
   logic [CFG_W-1:0] eff_ways;
   logic             priming;
   logic             bad;
   logic             last_prime;
   logic             do_pop;
   logic             produce;
   chain_ctrl_type   ctrl;
   entry_type        key;
   entry_type        head;
   logic             full;

   // Handshakes: take an item while the result register is free or draining
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid & csr_ready;
   assign req_stall = rsp_valid_ff & rsp_stall;
   assign take      = req_valid & ~req_stall;

   // Clamp the number of runs
   always_comb begin
      if (active_ff == '0) begin
         eff_ways = CFG_W'(1);
      end else if (active_ff > CAP_W) begin
         eff_ways = CAP_W;
      end else begin
         eff_ways = active_ff;
      end
   end

   // Phase seen by this item, with a finished pass restarting
   always_comb begin
      restart   = (phase_ff == PH_DONE);
      phase_cur = restart ? PH_PRIMING : phase_ff;
      cnt_cur   = restart ? '0 : primed_ff;
      cnt_inc   = cnt_cur + CFG_W'(1);
      priming   = (phase_cur == PH_PRIMING);
   end

   // Output decode: source check, chain command, result
   always_comb begin
      case (phase_cur)
         PH_PRIMING: begin
            bad        = ({1'b0, req_source} != cnt_cur);
            last_prime = (cnt_inc >= eff_ways);
         end
         PH_MERGING: begin
            bad        = (req_source != awaited_ff);
            last_prime = 1'b1;
         end
         default: begin
            bad        = 1'b0;
            last_prime = 1'b0;
         end
      endcase

      do_pop      = take & ~bad & last_prime;
      produce     = take & (bad | do_pop);
      ctrl.flush  = (take & restart) | csr_write;
      ctrl.insert = take & ~bad & ~req_exhausted & ~full;
      ctrl.pop    = do_pop;
      key.valid   = 1'b1;
      key.source  = req_source;
      key.value   = req_value;
   end

   kwm_chain #(
      .WAYS (WAYS)
   ) u_chain (
      .clock (clock),
      .reset (reset),
      .ctrl  (ctrl),
      .key   (key),
      .head  (head),
      .full  (full)
   );

   // Next state of the pass
   always_comb begin
      phase_in   = phase_ff;
      primed_in  = primed_ff;
      awaited_in = awaited_ff;
      active_in  = active_ff;
      if (csr_write) begin
         phase_in   = PH_PRIMING;
         primed_in  = '0;
         awaited_in = '0;
         active_in  = csr_active_ways;
      end else if (take) begin
         phase_in  = phase_cur;
         primed_in = cnt_cur;
         if (restart) begin
            awaited_in = '0;
         end
         if (!bad && priming) begin
            primed_in = cnt_inc;
         end
         if (do_pop) begin
            if (head.valid) begin
               phase_in   = PH_MERGING;
               awaited_in = head.source;
            end else begin
               phase_in = PH_DONE;
            end
         end
      end
   end

   // Result register: load on a result, clear once transferred
   always_comb begin
      rsp_valid_in        = produce | (rsp_valid_ff & rsp_stall);
      rsp_out_source_in   = rsp_out_source_ff;
      rsp_out_value_in    = rsp_out_value_ff;
      rsp_done_res_in     = rsp_done_res_ff;
      rsp_source_error_in = rsp_source_error_ff;
      if (produce) begin
         if (bad) begin
            rsp_out_source_in   = req_source;
            rsp_out_value_in    = '0;
            rsp_done_res_in     = 1'b0;
            rsp_source_error_in = 1'b1;
         end else if (head.valid) begin
            rsp_out_source_in   = head.source;
            rsp_out_value_in    = head.value;
            rsp_done_res_in     = 1'b0;
            rsp_source_error_in = 1'b0;
         end else begin
            rsp_out_source_in   = '0;
            rsp_out_value_in    = '0;
            rsp_done_res_in     = 1'b1;
            rsp_source_error_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_PRIMING;
         primed_ff    <= '0;
         awaited_ff   <= '0;
         active_ff    <= ACTIVE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         primed_ff    <= primed_in;
         awaited_ff   <= awaited_in;
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_out_source_ff   <= rsp_out_source_in;
      rsp_out_value_ff    <= rsp_out_value_in;
      rsp_done_res_ff     <= rsp_done_res_in;
      rsp_source_error_ff <= rsp_source_error_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_source   = rsp_out_source_ff;
   assign rsp_out_value    = rsp_out_value_ff;
   assign rsp_done_res     = rsp_done_res_ff;
   assign rsp_source_error = rsp_source_error_ff;

   `KWM_ASSERT_IMP(a_stall_only_when_held, clock, reset, !rsp_valid_ff, !req_stall)
   `KWM_ASSERT_IMP(a_prime_count_in_range, clock, reset, phase_ff == PH_PRIMING, primed_ff < eff_ways)
   `KWM_ASSERT_NXT(a_awaited_tracks_emit, clock, reset, do_pop && head.valid && !csr_write, (awaited_ff == rsp_out_source_ff) && (phase_ff == PH_MERGING))
   `KWM_ASSERT_NXT(a_empty_pop_ends_pass, clock, reset, do_pop && !head.valid && !csr_write, (phase_ff == PH_DONE) && rsp_done_res_ff)

endmodule

`default_nettype wire

@@ sim/kway_merge_min_queue_checker.sv @@
// Checker for the k-way merge min queue: watches every transfer, predicts results, compares
`timescale 1ns / 100ps

module kway_merge_min_queue_checker #(
   parameter int WAYS = kwm_pkg::WAYS_DEF
) (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        req_valid,
   input  wire                        req_stall,
   input  wire  [kwm_pkg::SRC_W-1:0]  req_source,
   input  wire  [kwm_pkg::VAL_W-1:0]  req_value,
   input  wire                        req_exhausted,
   input  wire                        rsp_valid,
   input  wire                        rsp_stall,
   input  wire  [kwm_pkg::SRC_W-1:0]  rsp_out_source,
   input  wire  [kwm_pkg::VAL_W-1:0]  rsp_out_value,
   input  wire                        rsp_done_res,
   input  wire                        rsp_source_error,
   input  wire                        csr_valid,
   input  wire                        csr_ready,
   input  wire  [kwm_pkg::CFG_W-1:0]  csr_active_ways,
   output int                         fail_count,
   output int                         pending_count
);

   import kwm_pkg::*;

   typedef struct packed {
      logic [SRC_W-1:0] source;
      logic [VAL_W-1:0] value;
      logic             done;
      logic             error;
   } emission_type;

   // Predicted state of the sorted chain and the pass
   logic [VAL_W-1:0] chain_value [WAYS];
   logic [SRC_W-1:0] chain_source [WAYS];
   int               chain_count;
   logic [3:0]       primed_count;
   logic [SRC_W-1:0] awaited_source;
   phase_type        phase;
   logic [CFG_W-1:0] ways_reg;

   emission_type     emissions_due [$];
   int               mismatches = 0;
   int               due_depth = 0;

   assign fail_count    = mismatches;
   assign pending_count = due_depth;

   // Clamp the way count: zero counts as one, cap at the cells and the source reach
   function automatic int ways_in_use(input logic [CFG_W-1:0] w);
      int n;
      n = int'(w);
      if (n < 1) n = 1;
      if (n > WAYS) n = WAYS;
      if (n > SRC_REACH) n = SRC_REACH;
      return n;
   endfunction

   function automatic emission_type wrong_source(input logic [SRC_W-1:0] src);
      emission_type r;
      r.source = src;
      r.value  = '0;
      r.done   = 1'b0;
      r.error  = 1'b1;
      return r;
   endfunction

   // Append a result to the ones still owed by the block
   task automatic owe_result(input emission_type r);
      emissions_due.insert(emissions_due.size(), r);
   endtask

   task automatic clear_pass();
      int i;
      for (i = 0; i < WAYS; i++) begin
         chain_value[i]  = '0;
         chain_source[i] = '0;
      end
      chain_count    = 0;
      primed_count   = '0;
      awaited_source = '0;
      phase          = PH_PRIMING;
   endtask

   // Insert a head value, keeping the chain ordered by value, then source
   task automatic insert_head(input logic [SRC_W-1:0] src, input logic [VAL_W-1:0] val);
      int pos;
      if (chain_count < WAYS) begin
         pos = chain_count;
         while (pos > 0 && (chain_value[pos-1] > val ||
                (chain_value[pos-1] == val && chain_source[pos-1] > src))) begin
            chain_value[pos]  = chain_value[pos-1];
            chain_source[pos] = chain_source[pos-1];
            pos--;
         end
         chain_value[pos]  = val;
         chain_source[pos] = src;
         chain_count++;
      end
   endtask

   // Pop the smallest head, or close the pass when nothing is held
   task automatic pop_smallest(output emission_type r);
      int i;
      r = '0;
      if (chain_count == 0) begin
         r.done = 1'b1;
         phase  = PH_DONE;
      end else begin
         r.source       = chain_source[0];
         r.value        = chain_value[0];
         awaited_source = chain_source[0];
         for (i = 0; i + 1 < chain_count; i++) begin
            chain_value[i]  = chain_value[i+1];
            chain_source[i] = chain_source[i+1];
         end
         chain_value[chain_count-1]  = '0;
         chain_source[chain_count-1] = '0;
         chain_count--;
         phase = PH_MERGING;
      end
   endtask

   // Work out what one accepted item causes
   task automatic merge_refill(input logic [SRC_W-1:0] src, input logic [VAL_W-1:0] val,
                               input logic ex);
      emission_type r;
      if (phase != PH_PRIMING && phase != PH_MERGING) clear_pass();
      if (phase == PH_PRIMING) begin
         if ({1'b0, src} != primed_count) begin
            owe_result(wrong_source(src));
         end else begin
            if (!ex) insert_head(src, val);
            primed_count = primed_count + 4'd1;
            if (int'(primed_count) >= ways_in_use(ways_reg)) begin
               pop_smallest(r);
               owe_result(r);
            end
         end
      end else if (src != awaited_source) begin
         owe_result(wrong_source(src));
      end else begin
         if (!ex) insert_head(src, val);
         pop_smallest(r);
         owe_result(r);
      end
   endtask

   // Sample all three channels at the rising edge
   always @(posedge clock) begin : watch
      emission_type got;
      emission_type want;
      if (reset) begin
         clear_pass();
         ways_reg = ACTIVE_RESET;
         emissions_due.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            ways_reg = csr_active_ways;
            clear_pass();
         end
         if (req_valid && !req_stall) merge_refill(req_source, req_value, req_exhausted);
         if (rsp_valid && !rsp_stall) begin
            got.source = rsp_out_source;
            got.value  = rsp_out_value;
            got.done   = rsp_done_res;
            got.error  = rsp_source_error;
            if (emissions_due.size() == 0) begin
               mismatches++;
               $display("%0t: expected no result, got source %0d value %0d",
                        $time, got.source, got.value,
                        " done %0b error %0b", got.done, got.error);
            end else begin
               want = emissions_due.pop_front();
               if (got !== want) begin
                  mismatches++;
                  $display("%0t: expected source %0d value %0d done %0b error %0b,",
                           $time, want.source, want.value, want.done, want.error,
                           " got source %0d value %0d done %0b error %0b",
                           got.source, got.value, got.done, got.error);
               end
            end
         end
      end
      due_depth = emissions_due.size();
   end

endmodule

@@ sim/kway_merge_min_queue_tb.sv @@
// Testbench top for the k-way merge min queue: clock, reset, stimulus and verdict
`timescale 1ns / 100ps

module kway_merge_min_queue_tb;

   import kwm_pkg::*;

   localparam int WAYS            = WAYS_DEF;
   localparam int MAX_RUN         = 16;
   localparam int ITEM_TARGET     = 450;
   localparam int SETTLE_CYCLES   = 4;
   localparam int DRAIN_CYCLES    = 10;
   localparam int HOLD_OFF_CYCLES = 120;
   localparam int CYCLE_LIMIT     = 400000;
   localparam logic [VAL_W-1:0] VAL_MAX = {VAL_W{1'b1}};

   typedef struct {
      logic [SRC_W-1:0] source;
      logic [VAL_W-1:0] value;
      logic             exhausted;
      bit               noise;
   } merge_item_type;

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_stall;
   logic [SRC_W-1:0] req_source;
   logic [VAL_W-1:0] req_value;
   logic             req_exhausted;
   logic             rsp_valid;
   logic             rsp_stall;
   logic [SRC_W-1:0] rsp_out_source;
   logic [VAL_W-1:0] rsp_out_value;
   logic             rsp_done_res;
   logic             rsp_source_error;
   logic             csr_valid;
   logic             csr_ready;
   logic [CFG_W-1:0] csr_active_ways;

   int               fail_count;
   int               pending_count;

   // Runs of the current pass and the item order they give
   logic [VAL_W-1:0] run_val [SRC_REACH][MAX_RUN];
   int               run_len [SRC_REACH];
   merge_item_type   pass_items [$];

   logic [CFG_W-1:0] cur_ways = ACTIVE_RESET;
   bit               no_gaps = 1'b0;
   bit               hold_off_req = 1'b0;
   int               merge_items = 0;
   int               noise_items = 0;
   int               pass_count = 0;
   int               cut_passes = 0;
   int               way_writes = 0;
   int               cycle_count = 0;

   kway_merge_min_queue #(.WAYS(WAYS)) DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_source       (req_source),
      .req_value        (req_value),
      .req_exhausted    (req_exhausted),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_source   (rsp_out_source),
      .rsp_out_value    (rsp_out_value),
      .rsp_done_res     (rsp_done_res),
      .rsp_source_error (rsp_source_error),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_active_ways  (csr_active_ways)
   );

   kway_merge_min_queue_checker #(.WAYS(WAYS)) merge_watch (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_source       (req_source),
      .req_value        (req_value),
      .req_exhausted    (req_exhausted),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_source   (rsp_out_source),
      .rsp_out_value    (rsp_out_value),
      .rsp_done_res     (rsp_done_res),
      .rsp_source_error (rsp_source_error),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_active_ways  (csr_active_ways),
      .fail_count       (fail_count),
      .pending_count    (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   function automatic int ways_in_use(input logic [CFG_W-1:0] w);
      int n;
      n = int'(w);
      if (n < 1) n = 1;
      if (n > WAYS) n = WAYS;
      if (n > SRC_REACH) n = SRC_REACH;
      return n;
   endfunction

   task automatic clear_runs();
      int s;
      for (s = 0; s < SRC_REACH; s++) run_len[s] = 0;
   endtask

   // Fill the runs of a pass; the shape picks spread, ties, disorder or values near the top
   task automatic make_runs(input int nways, input bit long_runs);
      int s, k, r, shape;
      logic [31:0] acc;
      shape = $urandom_range(0, 3);
      for (s = 0; s < SRC_REACH; s++) begin
         r = $urandom_range(0, 99);
         if (s >= nways) run_len[s] = 0;
         else if (long_runs) run_len[s] = $urandom_range(10, MAX_RUN);
         else if (r < 10) run_len[s] = 0;
         else if (r < 85) run_len[s] = $urandom_range(1, 4);
         else run_len[s] = $urandom_range(5, MAX_RUN);
         case (shape)
            0: acc = $urandom_range(0, 1000);
            1: acc = $urandom_range(0, 3);
            default: acc = {1'b0, VAL_W'($urandom())};
         endcase
         for (k = 0; k < run_len[s]; k++) begin
            case (shape)
               0: acc = acc + $urandom_range(0, 1000);
               1: acc = acc + $urandom_range(0, 1);
               2: acc = {1'b0, VAL_W'($urandom())};
               default: acc = acc + $urandom_range(0, 1 << 20);
            endcase
            if (acc > {1'b0, VAL_MAX}) acc = {1'b0, VAL_MAX};
            run_val[s][k] = acc[VAL_W-1:0];
         end
      end
   endtask

   // Queue one item of the pass, sometimes behind a wrong-source item
   task automatic queue_item(input int src, input logic [VAL_W-1:0] v, input logic ex,
                             input int noise_pct);
      merge_item_type it;
      if ($urandom_range(0, 99) < noise_pct) begin
         it.source    = SRC_W'(src + $urandom_range(1, SRC_REACH - 1));
         it.value     = VAL_W'($urandom());
         it.exhausted = 1'($urandom());
         it.noise     = 1'b1;
         pass_items.insert(pass_items.size(), it);
      end
      it.source    = SRC_W'(src);
      it.value     = ex ? VAL_W'($urandom()) : v;
      it.exhausted = ex;
      it.noise     = 1'b0;
      pass_items.insert(pass_items.size(), it);
   endtask

   // Prime every active run in order, then follow the refill order the heads dictate
   task automatic build_pass(input int nways, input int noise_pct);
      int idx [SRC_REACH];
      logic live [SRC_REACH];
      logic [VAL_W-1:0] head [SRC_REACH];
      int s, pick;
      pass_items.delete();
      for (s = 0; s < SRC_REACH; s++) begin
         live[s] = 1'b0;
         idx[s]  = 1;
         head[s] = '0;
      end
      for (s = 0; s < nways; s++) begin
         live[s] = (run_len[s] > 0);
         head[s] = run_val[s][0];
         queue_item(s, head[s], !live[s], noise_pct);
      end
      pick = 0;
      while (pick >= 0) begin
         pick = -1;
         for (s = 0; s < nways; s++)
            if (live[s] && (pick < 0 || head[s] < head[pick])) pick = s;
         if (pick >= 0) begin
            if (idx[pick] < run_len[pick]) begin
               head[pick] = run_val[pick][idx[pick]];
               idx[pick]++;
               queue_item(pick, head[pick], 1'b0, noise_pct);
            end else begin
               live[pick] = 1'b0;
               queue_item(pick, '0, 1'b1, noise_pct);
            end
         end
      end
   endtask

   // Offer one item and hold it until the transfer; valid stays up for a back-to-back item
   task automatic send_item(input merge_item_type it);
      int gap;
      gap = no_gaps ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_source    <= it.source;
      req_value     <= it.value;
      req_exhausted <= it.exhausted;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
      if (it.noise) noise_items++;
      else merge_items++;
   endtask

   task automatic run_pass(input bit cut);
      int count, k;
      count = pass_items.size();
      if (cut && count > 1) begin
         count = $urandom_range(1, count - 1);
         cut_passes++;
      end
      for (k = 0; k < count; k++) send_item(pass_items[k]);
      pass_count++;
   endtask

   // Write the way count once the block has gone quiet
   task automatic write_ways(input logic [CFG_W-1:0] w);
      req_valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_valid       <= 1'b1;
      csr_active_ways <= w;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
      cur_ways = w;
      way_writes++;
   endtask

   // Result side: random stalls, free stretches, and one long hold-off on request
   initial begin : result_side
      int n;
      rsp_stall = 1'b0;
      @(negedge clock);
      forever begin
         if (hold_off_req) begin
            rsp_stall <= 1'b1;
            for (n = 0; n < HOLD_OFF_CYCLES; n++) @(negedge clock);
            hold_off_req = 1'b0;
         end else begin
            n = pick_gap();
            if (n == 0) begin
               rsp_stall <= 1'b0;
               if ($urandom_range(0, 99) < 5) n = $urandom_range(30, 80);
               else n = $urandom_range(1, 12);
            end else begin
               rsp_stall <= 1'b1;
            end
            repeat (n) @(negedge clock);
         end
      end
   end

   // Abort on a hung run
   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("end of test: mismatches");
      $finish;
   end

   initial begin : stimulus
      logic [CFG_W-1:0] sweep [4];
      bit cut;
      int wi;
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_source      = '0;
      req_value       = '0;
      req_exhausted   = 1'b0;
      csr_valid       = 1'b0;
      csr_active_ways = ACTIVE_RESET;
      sweep[0] = 4'd2;
      sweep[1] = 4'd8;
      sweep[2] = 4'd5;
      sweep[3] = 4'd1;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset width of eight: extreme values, ties, exhausted primes
      clear_runs();
      run_len[0] = 1; run_val[0][0] = VAL_MAX;
      run_len[1] = 1; run_val[1][0] = '0;
      run_len[3] = 2; run_val[3][0] = 31'd5; run_val[3][1] = 31'd5;
      run_len[4] = 1; run_val[4][0] = 31'd5;
      run_len[5] = 1; run_val[5][0] = 31'd1;
      run_len[7] = 1; run_val[7][0] = VAL_MAX;
      build_pass(ways_in_use(cur_ways), 0);
      run_pass(1'b0);

      // One way, exhausted at once: done straight from the prime
      write_ways(4'd1);
      clear_runs();
      build_pass(ways_in_use(cur_ways), 0);
      run_pass(1'b0);

      // Zero ways counts as one; wrong sources while priming and while merging
      write_ways(4'd0);
      clear_runs();
      run_len[0] = 1; run_val[0][0] = 31'd7;
      build_pass(ways_in_use(cur_ways), 100);
      run_pass(1'b0);

      // Width above the cell count, long runs and a long result hold-off
      write_ways(4'd15);
      make_runs(ways_in_use(cur_ways), 1'b1);
      build_pass(ways_in_use(cur_ways), 0);
      no_gaps      = 1'b1;
      hold_off_req = 1'b1;
      run_pass(1'b0);
      no_gaps = 1'b0;

      // Random passes; a cut pass is followed by a restart through the register when another pass comes
      cut = 1'b0;
      wi  = 0;
      while (merge_items < ITEM_TARGET) begin
         if (cut || $urandom_range(0, 99) < 30) begin
            if (wi < 4) write_ways(sweep[wi]);
            else write_ways(CFG_W'($urandom_range(0, 15)));
            wi++;
         end
         cut = ($urandom_range(0, 99) < 10);
         make_runs(ways_in_use(cur_ways), 1'b0);
         build_pass(ways_in_use(cur_ways), ($urandom_range(0, 99) < 30) ? 10 : 0);
         run_pass(cut);
      end

      // Drain and let the block settle
      req_valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("Merged %0d items in %0d passes (%0d cut short), with %0d wrong-source items,",
               merge_items, pass_count, cut_passes, noise_items);
      $display("%0d way-count writes and one long result hold-off backing up the input.",
               way_writes);
      if (fail_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
